[sv/diff_drive_odometry_unit_assert.svh]
// assertion macros for the odometry unit
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// property holds at every edge outside reset
`define DDO_HOLDS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ddo assertion failed");

// trigger implies a condition in the cycle after the trigger
`define DDO_FOLLOWS(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("ddo sequence assertion failed");

`endif

[sv/ddo_pkg.sv]
`default_nettype none
package ddo_pkg;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int ANG_BITS     = 30;
   localparam int TABLE_LEN    = 30;
   localparam int CORDIC_ITER  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int IDX_W        = $clog2(TABLE_LEN);

   localparam int CFG_W   = 31;
   localparam int DATA_W  = 32;
   localparam int HEAD_W  = FRAC_BITS + 3;
   localparam int TRIG_W  = FRAC_BITS + 4;
   localparam int OPA_W   = 64;
   localparam int OPB_W   = 34;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int QUO_W   = OPA_W + 1;
   localparam int REM_W   = CFG_W;
   localparam int MUL_STEPS = OPB_W;
   localparam int DIV_STEPS = OPA_W;
   localparam int CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int Z_W     = 35;
   localparam int XY_W    = 34;
   localparam int CSR_IDX_W = 2;

   localparam longint PI_Q32          = 64'sd13493037705;
   localparam longint PI_Q30          = 64'sd3373259426;
   localparam longint HALF_PI_Q30     = 64'sd1686629713;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
   localparam longint TWO_PI_Q =
      (2 * PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   localparam longint HEAD_LOW = -((TWO_PI_Q + 1) / 2);

   localparam logic [CFG_W-1:0] RST_RADIUS     = CFG_W'(9830);
   localparam logic [CFG_W-1:0] RST_SEPARATION = CFG_W'(29491);
   localparam logic [CFG_W-1:0] RST_TIME_STEP  = CFG_W'(6554);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS     = 2'd0,
      CSR_SEPARATION = 2'd1,
      CSR_TIME_STEP  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_C_HALF, S_C_LEFT, S_C_RIGHT,
      S_T_BU, S_T_DIFF, S_T_BR, S_T_VC, S_T_DX,
      S_T_VS, S_T_DY, S_T_DH, S_T_WRAP, S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

   typedef struct packed {
      logic                     clip;
      logic signed [DATA_W-1:0] value;
   } sat_type;

   function automatic logic [ANG_BITS-1:0] atan_q30(input logic [IDX_W-1:0] i);
      logic [ANG_BITS-1:0] a;
      case (i)
         5'd0:  a = 30'd843314857;
         5'd1:  a = 30'd497837830;
         5'd2:  a = 30'd263043837;
         5'd3:  a = 30'd133525159;
         5'd4:  a = 30'd67021687;
         5'd5:  a = 30'd33543516;
         5'd6:  a = 30'd16775851;
         5'd7:  a = 30'd8388437;
         5'd8:  a = 30'd4194283;
         5'd9:  a = 30'd2097149;
         default: a = ANG_BITS'(30'd1 << (ANG_BITS - int'(i)));
      endcase
      return a;
   endfunction

   function automatic logic signed [PROD_W-1:0] rnd_shift(
         input logic signed [PROD_W-1:0] p, input int n);
      logic signed [PROD_W-1:0] bias;
      bias = '0;
      bias[n-1] = 1'b1;
      return (p + bias) >>> n;
   endfunction

   function automatic sat_type sat32(input logic signed [PROD_W-1:0] v);
      sat_type r;
      r.clip = !((&v[PROD_W-1:DATA_W-1]) || (~|v[PROD_W-1:DATA_W-1]));
      if (r.clip) begin
         r.value = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[sv/ddo_if.sv]
`default_nettype none
interface ddo_req_if import ddo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] linear_speed;
   logic signed [DATA_W-1:0] turn_rate;
   modport source(output valid, op, linear_speed, turn_rate, input ready);
   modport sink(input valid, op, linear_speed, turn_rate, output ready);
endinterface

interface ddo_rsp_if import ddo_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] left_wheel_rate;
   logic signed [DATA_W-1:0] right_wheel_rate;
   logic signed [DATA_W-1:0] pos_x;
   logic signed [DATA_W-1:0] pos_y;
   logic signed [HEAD_W-1:0] heading;
   logic signed [DATA_W-1:0] body_speed;
   logic signed [DATA_W-1:0] body_yaw_rate;
   logic                     saturated;
   modport source(output valid, left_wheel_rate, right_wheel_rate, pos_x, pos_y, heading,
                  body_speed, body_yaw_rate, saturated, input ready);
   modport sink(input valid, left_wheel_rate, right_wheel_rate, pos_x, pos_y, heading,
                body_speed, body_yaw_rate, saturated, output ready);
endinterface
`default_nettype wire

[sv/diff_drive_odometry_unit.sv]
// one transaction at a time; the shared serial multiply/divide unit does the arithmetic:
// multiplies take one multiplier bit per cycle and divides one quotient bit,
// a tick uses seven multiplies and two divides, a command one multiply and two divides
// reset: registers to 0.15 m radius, 0.45 m separation, 0.1 s step; rates and pose to zero
`default_nettype none
`include "diff_drive_odometry_unit_assert.svh"
module diff_drive_odometry_unit import ddo_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   ddo_req_if.sink             req_chan,
   ddo_rsp_if.source           rsp_chan,
   input  wire                 csr_we,
   input  wire [CSR_IDX_W-1:0] csr_index,
   input  wire [CFG_W-1:0]     csr_wdata
);
   state_type state_ff, state_in;
   logic      issued_ff, issued_in;

   logic [CFG_W-1:0] rad_ff, sep_ff, dt_ff;
   logic [CFG_W-1:0] rad_eff, sep_eff;

   logic signed [DATA_W-1:0] u_ff, r_ff;
   logic signed [OPA_W-1:0]  half_ff, tmp_ff;
   logic signed [DATA_W-1:0] bu_ff, br_ff;
   logic signed [DATA_W-1:0] left_ff, right_ff, x_ff, y_ff;
   logic signed [HEAD_W-1:0] heading_ff;
   logic                     sat_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] o_left_ff, o_right_ff, o_x_ff, o_y_ff, o_bu_ff, o_br_ff;
   logic signed [HEAD_W-1:0] o_head_ff;
   logic                     o_sat_ff;

   md_ctrl_type              md_ctrl;
   md_stat_type              md_stat;
   logic signed [OPA_W-1:0]  opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [PROD_W-1:0] product;
   logic signed [QUO_W-1:0]  quotient;
   logic        [REM_W-1:0]  remainder;
   logic signed [PROD_W-1:0] quo_wide;

   logic                     trig_valid;
   logic signed [TRIG_W-1:0] cos_val, sin_val;

   logic                     accept, load_out;
   logic signed [OPA_W-1:0]  u64, half_sum, half_diff;
   sat_type                  sat_res;
   logic signed [PROD_W-1:0] rnd_res, rnd_half, pos_sum;
   logic        [REM_W-1:0]  wrap_mod;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rad_eff  = (rad_ff == '0) ? CFG_W'(1) : rad_ff;
   assign sep_eff  = (sep_ff == '0) ? CFG_W'(1) : sep_ff;
   assign quo_wide = {{(PROD_W-QUO_W){quotient[QUO_W-1]}}, quotient};
   assign u64      = {{(OPA_W-DATA_W){u_ff[DATA_W-1]}}, u_ff};
   assign half_diff = (u64 - half_ff) <<< FRAC_BITS;
   assign half_sum  = (u64 + half_ff) <<< FRAC_BITS;

   ddo_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (md_ctrl),
      .opa       (opa),
      .opb       (opb),
      .stat      (md_stat),
      .product   (product),
      .quotient  (quotient),
      .remainder (remainder)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_chan.op == OP_TICK)),
      .angle   (heading_ff),
      .valid   (trig_valid),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   // operand selection, sequencing
   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      md_ctrl.start  = 1'b0;
      md_ctrl.is_div = 1'b0;
      opa            = '0;
      opb            = '0;
      load_out       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_chan.op == OP_TICK) ? S_T_BU : S_C_HALF;
            end
         end
         S_C_HALF: begin
            opa = {{(OPA_W-DATA_W){r_ff[DATA_W-1]}}, r_ff};
            opb = {3'b000, sep_eff};
         end
         S_C_LEFT: begin
            md_ctrl.is_div = 1'b1;
            opa = half_diff;
            opb = {3'b000, rad_eff};
         end
         S_C_RIGHT: begin
            md_ctrl.is_div = 1'b1;
            opa = half_sum;
            opb = {3'b000, rad_eff};
         end
         S_T_BU: begin
            opa = {{(OPA_W-DATA_W){left_ff[DATA_W-1]}}, left_ff}
                + {{(OPA_W-DATA_W){right_ff[DATA_W-1]}}, right_ff};
            opb = {3'b000, rad_eff};
         end
         S_T_DIFF: begin
            opa = {{(OPA_W-DATA_W){right_ff[DATA_W-1]}}, right_ff}
                - {{(OPA_W-DATA_W){left_ff[DATA_W-1]}}, left_ff};
            opb = {3'b000, rad_eff};
         end
         S_T_BR: begin
            md_ctrl.is_div = 1'b1;
            opa = tmp_ff;
            opb = {3'b000, sep_eff};
         end
         S_T_VC: begin
            opa = {{(OPA_W-DATA_W){bu_ff[DATA_W-1]}}, bu_ff};
            opb = {{(OPB_W-TRIG_W){cos_val[TRIG_W-1]}}, cos_val};
         end
         S_T_VS: begin
            opa = {{(OPA_W-DATA_W){bu_ff[DATA_W-1]}}, bu_ff};
            opb = {{(OPB_W-TRIG_W){sin_val[TRIG_W-1]}}, sin_val};
         end
         S_T_DX, S_T_DY: begin
            opa = tmp_ff;
            opb = {3'b000, dt_ff};
         end
         S_T_DH: begin
            opa = {{(OPA_W-DATA_W){br_ff[DATA_W-1]}}, br_ff};
            opb = {3'b000, dt_ff};
         end
         S_T_WRAP: begin
            md_ctrl.is_div = 1'b1;
            opa = tmp_ff;
            opb = OPB_W'(TWO_PI_Q);
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_IDLE && state_ff != S_OUT) begin
         md_ctrl.start = !issued_ff
                       && (trig_valid || (state_ff != S_T_VC && state_ff != S_T_VS));
         if (md_ctrl.start) begin
            issued_in = 1'b1;
         end
         if (md_stat.done) begin
            issued_in = 1'b0;
            case (state_ff)
               S_C_HALF:  state_in = S_C_LEFT;
               S_C_LEFT:  state_in = S_C_RIGHT;
               S_C_RIGHT: state_in = S_OUT;
               S_T_BU:    state_in = S_T_DIFF;
               S_T_DIFF:  state_in = S_T_BR;
               S_T_BR:    state_in = S_T_VC;
               S_T_VC:    state_in = S_T_DX;
               S_T_DX:    state_in = S_T_VS;
               S_T_VS:    state_in = S_T_DY;
               S_T_DY:    state_in = S_T_DH;
               S_T_DH:    state_in = S_T_WRAP;
               S_T_WRAP:  state_in = S_OUT;
               default:   state_in = S_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   // result shaping
   always_comb begin
      rnd_res  = rnd_shift(product, FRAC_BITS);
      rnd_half = rnd_shift(product, FRAC_BITS + 1);
      pos_sum  = '0;
      sat_res  = sat32(quo_wide);
      case (state_ff)
         S_T_BU:  sat_res = sat32(rnd_half);
         S_T_DX: begin
            pos_sum = {{(PROD_W-DATA_W){x_ff[DATA_W-1]}}, x_ff} + rnd_res;
            sat_res = sat32(pos_sum);
         end
         S_T_DY: begin
            pos_sum = {{(PROD_W-DATA_W){y_ff[DATA_W-1]}}, y_ff} + rnd_res;
            sat_res = sat32(pos_sum);
         end
         default: sat_res = sat32(quo_wide);
      endcase
      wrap_mod = (tmp_ff[OPA_W-1] && (remainder != '0))
               ? REM_W'(TWO_PI_Q) - remainder : remainder;
   end

   // datapath and pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff     <= RST_RADIUS;
         sep_ff     <= RST_SEPARATION;
         dt_ff      <= RST_TIME_STEP;
         left_ff    <= '0;
         right_ff   <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RADIUS:     rad_ff <= csr_wdata;
               CSR_SEPARATION: sep_ff <= csr_wdata;
               CSR_TIME_STEP:  dt_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (md_stat.done) begin
            case (state_ff)
               S_C_LEFT:  left_ff  <= sat_res.value;
               S_C_RIGHT: right_ff <= sat_res.value;
               S_T_DX:    x_ff     <= sat_res.value;
               S_T_DY:    y_ff     <= sat_res.value;
               S_T_WRAP:  heading_ff <= HEAD_W'(wrap_mod) + HEAD_W'(HEAD_LOW);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         u_ff   <= req_chan.linear_speed;
         r_ff   <= req_chan.turn_rate;
         bu_ff  <= '0;
         br_ff  <= '0;
         sat_ff <= 1'b0;
      end else if (md_stat.done) begin
         case (state_ff)
            S_C_HALF: half_ff <= rnd_half[OPA_W-1:0];
            S_C_LEFT, S_C_RIGHT, S_T_DX, S_T_DY: sat_ff <= sat_ff | sat_res.clip;
            S_T_BU: begin
               bu_ff  <= sat_res.value;
               sat_ff <= sat_ff | sat_res.clip;
            end
            S_T_DIFF: tmp_ff <= product[OPA_W-1:0];
            S_T_BR: begin
               br_ff  <= sat_res.value;
               sat_ff <= sat_ff | sat_res.clip;
            end
            S_T_VC, S_T_VS: tmp_ff <= rnd_res[OPA_W-1:0];
            S_T_DH: tmp_ff <= {{(OPA_W-HEAD_W){heading_ff[HEAD_W-1]}}, heading_ff}
                            + rnd_res[OPA_W-1:0] - OPA_W'(HEAD_LOW);
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         o_left_ff  <= left_ff;
         o_right_ff <= right_ff;
         o_x_ff     <= x_ff;
         o_y_ff     <= y_ff;
         o_head_ff  <= heading_ff;
         o_bu_ff    <= bu_ff;
         o_br_ff    <= br_ff;
         o_sat_ff   <= sat_ff;
      end
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.left_wheel_rate  = o_left_ff;
   assign rsp_chan.right_wheel_rate = o_right_ff;
   assign rsp_chan.pos_x            = o_x_ff;
   assign rsp_chan.pos_y            = o_y_ff;
   assign rsp_chan.heading          = o_head_ff;
   assign rsp_chan.body_speed       = o_bu_ff;
   assign rsp_chan.body_yaw_rate    = o_br_ff;
   assign rsp_chan.saturated        = o_sat_ff;

   `DDO_HOLDS(a_ready_unit_idle, req_chan.ready |-> !md_stat.busy)
   `DDO_FOLLOWS(a_accept_leaves_idle, accept, state_ff != S_IDLE)
   `DDO_HOLDS(a_heading_range, (heading_ff >= HEAD_LOW) && (heading_ff < HEAD_LOW + TWO_PI_Q))
   `DDO_HOLDS(a_trig_before_use, md_ctrl.start && (state_ff == S_T_VC) |-> trig_valid)
endmodule
`default_nettype wire

[sv/ddo_muldiv.sv]
`default_nettype none
module ddo_muldiv import ddo_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  md_ctrl_type               ctrl,
   input  wire  signed [OPA_W-1:0]   opa,
   input  wire  signed [OPB_W-1:0]   opb,
   output md_stat_type               stat,
   output logic signed [PROD_W-1:0]  product,
   output logic signed [QUO_W-1:0]   quotient,
   output logic        [REM_W-1:0]   remainder
);
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             is_div_ff, is_div_in;
   logic             neg_ff, neg_in;
   logic [OPA_W-1:0] mag_a_ff, mag_a_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [OPA_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] den_ff, den_in;

   logic [OPA_W:0]   sum;
   logic [REM_W:0]   shifted;
   logic [REM_W+1:0] trial;
   logic             fits;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      mag_a_in  = mag_a_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      sum       = acc_ff[0] ? {1'b0, acc_ff[PROD_W-1:OPB_W]} + {1'b0, mag_a_ff}
                            : {1'b0, acc_ff[PROD_W-1:OPB_W]};
      shifted   = {rem_ff, quo_ff[OPA_W-1]};
      trial     = {1'b0, shifted} - {2'b00, den_ff};
      fits      = !trial[REM_W+1];
      if (ctrl.start) begin
         busy_in   = 1'b1;
         is_div_in = ctrl.is_div;
         mag_a_in  = opa[OPA_W-1] ? OPA_W'(-opa) : OPA_W'(opa);
         neg_in    = ctrl.is_div ? opa[OPA_W-1] : (opa[OPA_W-1] ^ opb[OPB_W-1]);
         acc_in    = {{OPA_W{1'b0}}, (opb[OPB_W-1] ? OPB_W'(-opb) : OPB_W'(opb))};
         quo_in    = opa[OPA_W-1] ? OPA_W'(-opa) : OPA_W'(opa);
         rem_in    = '0;
         den_in    = opb[REM_W-1:0];
         cnt_in    = ctrl.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
      end else if (busy_ff) begin
         if (is_div_ff) begin
            rem_in = fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
            quo_in = {quo_ff[OPA_W-2:0], fits};
         end else begin
            acc_in = {sum, acc_ff[OPB_W-1:1]};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      mag_a_ff  <= mag_a_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
   assign quotient  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign remainder = rem_ff;
endmodule
`default_nettype wire

[sv/ddo_cordic.sv]
`default_nettype none
module ddo_cordic import ddo_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire  signed [HEAD_W-1:0]  angle,
   output logic                      valid,
   output logic signed [TRIG_W-1:0]  cos_out,
   output logic signed [TRIG_W-1:0]  sin_out
);
   localparam int SHIFT = ANG_BITS - FRAC_BITS;

   logic                   busy_ff, busy_in;
   logic                   valid_ff, valid_in;
   logic                   neg_ff, neg_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;

   logic signed [Z_W-1:0]  z0;
   logic signed [XY_W-1:0] sx, sy, rx, ry;
   logic signed [Z_W-1:0]  at;

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      neg_in   = neg_ff;
      idx_in   = idx_ff;
      z_in     = z_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z0 = {{(Z_W-HEAD_W){angle[HEAD_W-1]}}, angle} <<< SHIFT;
      sx = y_ff >>> idx_ff;
      sy = x_ff >>> idx_ff;
      at = Z_W'(atan_q30(idx_ff));
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         idx_in   = '0;
         x_in     = XY_W'(CORDIC_GAIN_Q30);
         y_in     = '0;
         neg_in   = 1'b0;
         z_in     = z0;
         if (z0 > Z_W'(HALF_PI_Q30)) begin
            z_in   = z0 - Z_W'(PI_Q30);
            neg_in = 1'b1;
         end else if (z0 < -Z_W'(HALF_PI_Q30)) begin
            z_in   = z0 + Z_W'(PI_Q30);
            neg_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - sx;
            y_in = y_ff + sy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + sx;
            y_in = y_ff - sy;
            z_in = z_ff + at;
         end
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == IDX_W'(CORDIC_ITER - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      neg_ff <= neg_in;
      idx_ff <= idx_in;
      z_ff   <= z_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   always_comb begin
      rx = (x_ff + (XY_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
      ry = (y_ff + (XY_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
   end

   assign valid   = valid_ff;
   assign cos_out = neg_ff ? -rx[TRIG_W-1:0] : rx[TRIG_W-1:0];
   assign sin_out = neg_ff ? -ry[TRIG_W-1:0] : ry[TRIG_W-1:0];
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
   import ddo_pkg::*;

   typedef struct {
      op_type                   op;
      logic signed [DATA_W-1:0] linear_speed;
      logic signed [DATA_W-1:0] turn_rate;
   } motion_item_type;

   typedef struct {
      logic signed [DATA_W-1:0] left_wheel_rate;
      logic signed [DATA_W-1:0] right_wheel_rate;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [HEAD_W-1:0] heading;
      logic signed [DATA_W-1:0] body_speed;
      logic signed [DATA_W-1:0] body_yaw_rate;
      logic                     saturated;
   } pose_report_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   ddo_req_if req_chan ();
   ddo_rsp_if rsp_chan ();

   diff_drive_odometry_unit DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // odometry state mirrored from the block
   logic [CFG_W-1:0] radius_q, separation_q, step_q;
   int left_rate_q, right_rate_q, x_q, y_q, heading_q;
   bit clip_seen;

   motion_item_type pending_motion[$];
   pose_report_type expected_poses[$];
   motion_item_type cur_item;
   int send_idle_max = 0;
   int recv_idle_max = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int errors = 0;
   int n_commands = 0;
   int n_ticks = 0;
   int n_clipped = 0;
   int idle_cycles = 0;

   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function int clip32(longint v);
      if (v > 64'sd2147483647) begin
         clip_seen = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clip_seen = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   task automatic sin_cos(input int h, output longint c, output longint s);
      longint z, x, y, nx, angle;
      bit flip;
      z = longint'(h) * (64'sd1 <<< (ANG_BITS - FRAC_BITS));
      x = CORDIC_GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z -= PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z += PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
         if (i < 10) begin
            case (i)
               0: angle = 843314857;
               1: angle = 497837830;
               2: angle = 263043837;
               3: angle = 133525159;
               4: angle = 67021687;
               5: angle = 33543516;
               6: angle = 16775851;
               7: angle = 8388437;
               8: angle = 4194283;
               default: angle = 2097149;
            endcase
         end else begin
            angle = 64'sd1 <<< (ANG_BITS - i);
         end
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= angle;
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += angle;
         end
         x = nx;
      end
      x = round_shift(x, ANG_BITS - FRAC_BITS);
      y = round_shift(y, ANG_BITS - FRAC_BITS);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_pose(input motion_item_type it);
      longint rad, sep, dt, half, l, r, c, s, tp, lowb, m;
      int bu, br;
      pose_report_type p;
      rad = (radius_q == 0) ? 1 : longint'(radius_q);
      sep = (separation_q == 0) ? 1 : longint'(separation_q);
      dt = longint'(step_q);
      bu = 0;
      br = 0;
      clip_seen = 1'b0;
      if (it.op == OP_COMMAND) begin
         half = round_shift(sep * longint'(it.turn_rate), FRAC_BITS + 1);
         left_rate_q = clip32(((longint'(it.linear_speed) - half) <<< FRAC_BITS) / rad);
         right_rate_q = clip32(((longint'(it.linear_speed) + half) <<< FRAC_BITS) / rad);
         n_commands++;
      end else begin
         l = left_rate_q;
         r = right_rate_q;
         bu = clip32(round_shift(rad * (l + r), FRAC_BITS + 1));
         br = clip32((rad * (r - l)) / sep);
         sin_cos(heading_q, c, s);
         x_q = clip32(longint'(x_q) +
                      round_shift(round_shift(longint'(bu) * c, FRAC_BITS) * dt, FRAC_BITS));
         y_q = clip32(longint'(y_q) +
                      round_shift(round_shift(longint'(bu) * s, FRAC_BITS) * dt, FRAC_BITS));
         tp = (2 * PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
         lowb = -((tp + 1) / 2);
         m = (longint'(heading_q) + round_shift(longint'(br) * dt, FRAC_BITS) - lowb) % tp;
         if (m < 0) m += tp;
         heading_q = int'(m + lowb);
         n_ticks++;
      end
      if (clip_seen) n_clipped++;
      p.left_wheel_rate = left_rate_q;
      p.right_wheel_rate = right_rate_q;
      p.pos_x = x_q;
      p.pos_y = y_q;
      p.heading = heading_q[HEAD_W-1:0];
      p.body_speed = bu;
      p.body_yaw_rate = br;
      p.saturated = clip_seen;
      expected_poses.push_back(p);
   endtask

   // driver
   always @(posedge clock) begin
      bit free;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.op <= OP_COMMAND;
         req_chan.linear_speed <= '0;
         req_chan.turn_rate <= '0;
      end else begin
         free = !req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            predict_pose(cur_item);
            free = 1'b1;
         end
         if (free) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_motion.size() > 0) begin
               cur_item = pending_motion.pop_front();
               req_chan.op <= cur_item.op;
               req_chan.linear_speed <= cur_item.linear_speed;
               req_chan.turn_rate <= cur_item.turn_rate;
               req_chan.valid <= 1'b1;
               send_gap <= $urandom_range(0, send_idle_max);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pose_report_type e;
      int n;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_poses.size() == 0) begin
               $display("%0t unexpected transaction on result channel", $realtime);
               errors++;
            end else begin
               e = expected_poses.pop_front();
               if (rsp_chan.left_wheel_rate !== e.left_wheel_rate) begin
                  $display("%0t left_wheel_rate exp %0d got %0d", $realtime,
                           e.left_wheel_rate, rsp_chan.left_wheel_rate);
                  errors++;
               end
               if (rsp_chan.right_wheel_rate !== e.right_wheel_rate) begin
                  $display("%0t right_wheel_rate exp %0d got %0d", $realtime,
                           e.right_wheel_rate, rsp_chan.right_wheel_rate);
                  errors++;
               end
               if (rsp_chan.pos_x !== e.pos_x) begin
                  $display("%0t pos_x exp %0d got %0d", $realtime, e.pos_x, rsp_chan.pos_x);
                  errors++;
               end
               if (rsp_chan.pos_y !== e.pos_y) begin
                  $display("%0t pos_y exp %0d got %0d", $realtime, e.pos_y, rsp_chan.pos_y);
                  errors++;
               end
               if (rsp_chan.heading !== e.heading) begin
                  $display("%0t heading exp %0d got %0d", $realtime,
                           e.heading, rsp_chan.heading);
                  errors++;
               end
               if (rsp_chan.body_speed !== e.body_speed) begin
                  $display("%0t body_speed exp %0d got %0d", $realtime,
                           e.body_speed, rsp_chan.body_speed);
                  errors++;
               end
               if (rsp_chan.body_yaw_rate !== e.body_yaw_rate) begin
                  $display("%0t body_yaw_rate exp %0d got %0d", $realtime,
                           e.body_yaw_rate, rsp_chan.body_yaw_rate);
                  errors++;
               end
               if (rsp_chan.saturated !== e.saturated) begin
                  $display("%0t saturated exp %0b got %0b", $realtime,
                           e.saturated, rsp_chan.saturated);
                  errors++;
               end
            end
            n = $urandom_range(0, recv_idle_max);
            recv_gap <= n;
            rsp_chan.ready <= (n == 0);
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= (recv_gap == 1);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d transactions outstanding", expected_poses.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic push_motion(input op_type op, input int ls, input int tr);
      motion_item_type it;
      it.op = op;
      it.linear_speed = ls;
      it.turn_rate = tr;
      pending_motion.push_back(it);
   endtask

   function automatic int draw_value();
      if ($urandom_range(0, 3) == 0) return int'($urandom());
      return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
   endfunction

   // each a command followed by a run of zero to six ticks, repeated until at least count items are queued
   task automatic push_random(input int count);
      int k;
      k = 0;
      while (k < count) begin
         push_motion(OP_COMMAND, draw_value(), draw_value());
         k++;
         repeat ($urandom_range(0, 6)) begin
            push_motion(OP_TICK, int'($urandom()), int'($urandom()));
            k++;
         end
      end
   endtask

   // checked between edges so that the driver's updates have settled
   task automatic drain();
      @(negedge clock);
      while (pending_motion.size() > 0 || req_chan.valid || expected_poses.size() > 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RADIUS:     radius_q = val;
         CSR_SEPARATION: separation_q = val;
         default:        step_q = val;
      endcase
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] s,
                               input logic [CFG_W-1:0] t);
      write_csr(CSR_RADIUS, r);
      write_csr(CSR_SEPARATION, s);
      write_csr(CSR_TIME_STEP, t);
      @(posedge clock);
   endtask

   initial begin
      radius_q = RST_RADIUS;
      separation_q = RST_SEPARATION;
      step_q = RST_TIME_STEP;
      left_rate_q = 0;
      right_rate_q = 0;
      x_q = 0;
      y_q = 0;
      heading_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ignored command fields on ticks
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_COMMAND, 0, 0);
      push_motion(OP_COMMAND, 32'sh10000, 32'sh8000);
      push_motion(OP_TICK, 32'sh7fffffff, 32'sh80000000);
      push_motion(OP_TICK, -1, -1);
      push_motion(OP_COMMAND, 32'sh7fffffff, 32'sh7fffffff);
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_COMMAND, 32'sh80000000, 32'sh80000000);
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_COMMAND, 32'sh7fffffff, 32'sh80000000);
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_COMMAND, 32'sh80000000, 32'sh7fffffff);
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_TICK, 0, 0);
      push_motion(OP_COMMAND, -32'sh10000, 32'sh40000);
      repeat (6) push_motion(OP_TICK, 0, 0);
      drain();

      send_idle_max = 7;
      recv_idle_max = 7;
      push_random(100);
      // sender holds until the result channel has caught up
      drain();
      send_idle_max = 0;
      recv_idle_max = 0;
      push_random(60);
      drain();

      set_geometry({CFG_W{1'b1}}, {CFG_W{1'b1}}, {CFG_W{1'b1}});
      send_idle_max = 7;
      recv_idle_max = 3;
      push_random(60);
      drain();

      set_geometry('0, '0, CFG_W'(1));
      push_random(40);
      drain();

      set_geometry(CFG_W'(1), {CFG_W{1'b1}}, CFG_W'(32'h10000));
      recv_idle_max = 7;
      push_random(40);
      drain();

      set_geometry(CFG_W'(9830), CFG_W'(2000), CFG_W'(32'h10000));
      send_idle_max = 3;
      push_random(100);
      drain();

      set_geometry(CFG_W'($urandom_range(1, 32'h40000)), CFG_W'($urandom_range(1, 32'h80000)),
                   CFG_W'($urandom_range(1, 32'h20000)));
      send_idle_max = 7;
      push_random(100);
      drain();

      set_geometry(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
      push_random(100);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d commands and %0d ticks over seven register settings",
               n_commands, n_ticks);
      $display("%0d transactions clipped, idle and stall gaps of 0 to 7 cycles", n_clipped);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
